// ===== sv/cu_rscu_pkg.sv =====
package cu_rscu_pkg;

    // Datapath sizing
    localparam int COUNT_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CNT_IN_W   = 32;                    // count_value port width
    localparam int RSCU_W     = 19;                    // rscu_fixed port width
    localparam int SUM_W      = COUNT_BITS + 3;        // up to six counts
    localparam int REM_W      = COUNT_BITS + 7;        // twice the shifted divisor
    localparam int QUOT_W     = FRAC_BITS + 3;         // integer part below 8
    localparam int STEP_W     = $clog2(QUOT_W + 1);

    // Synonymous families of the standard code
    localparam int NUM_FAM   = 21;
    localparam int FAM_SLOTS = 6;

    // Family id of each codon: K N T R S I M Q H P L E D A G V stop Y C W F
    localparam logic [4:0] FAM_OF_CODON [64] = '{
        5'd0,  5'd1,  5'd0,  5'd1,  5'd2,  5'd2,  5'd2,  5'd2,
        5'd3,  5'd4,  5'd3,  5'd4,  5'd5,  5'd5,  5'd6,  5'd5,
        5'd7,  5'd8,  5'd7,  5'd8,  5'd9,  5'd9,  5'd9,  5'd9,
        5'd3,  5'd3,  5'd3,  5'd3,  5'd10, 5'd10, 5'd10, 5'd10,
        5'd11, 5'd12, 5'd11, 5'd12, 5'd13, 5'd13, 5'd13, 5'd13,
        5'd14, 5'd14, 5'd14, 5'd14, 5'd15, 5'd15, 5'd15, 5'd15,
        5'd16, 5'd17, 5'd16, 5'd17, 5'd4,  5'd4,  5'd4,  5'd4,
        5'd16, 5'd18, 5'd19, 5'd18, 5'd10, 5'd20, 5'd10, 5'd20
    };

    localparam logic [2:0] FAM_SIZE [NUM_FAM] = '{
        3'd2, 3'd2, 3'd4, 3'd6, 3'd6, 3'd3, 3'd1, 3'd2, 3'd2, 3'd4, 3'd6,
        3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd3, 3'd2, 3'd2, 3'd1, 3'd2
    };

    localparam logic [5:0] FAM_MEMBER [NUM_FAM][FAM_SLOTS] = '{
        '{6'd0,  6'd2,  6'd0,  6'd0,  6'd0,  6'd0 },   // K
        '{6'd1,  6'd3,  6'd0,  6'd0,  6'd0,  6'd0 },   // N
        '{6'd4,  6'd5,  6'd6,  6'd7,  6'd0,  6'd0 },   // T
        '{6'd8,  6'd10, 6'd24, 6'd25, 6'd26, 6'd27},   // R
        '{6'd9,  6'd11, 6'd52, 6'd53, 6'd54, 6'd55},   // S
        '{6'd12, 6'd13, 6'd15, 6'd0,  6'd0,  6'd0 },   // I
        '{6'd14, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0 },   // M
        '{6'd16, 6'd18, 6'd0,  6'd0,  6'd0,  6'd0 },   // Q
        '{6'd17, 6'd19, 6'd0,  6'd0,  6'd0,  6'd0 },   // H
        '{6'd20, 6'd21, 6'd22, 6'd23, 6'd0,  6'd0 },   // P
        '{6'd28, 6'd29, 6'd30, 6'd31, 6'd60, 6'd62},   // L
        '{6'd32, 6'd34, 6'd0,  6'd0,  6'd0,  6'd0 },   // E
        '{6'd33, 6'd35, 6'd0,  6'd0,  6'd0,  6'd0 },   // D
        '{6'd36, 6'd37, 6'd38, 6'd39, 6'd0,  6'd0 },   // A
        '{6'd40, 6'd41, 6'd42, 6'd43, 6'd0,  6'd0 },   // G
        '{6'd44, 6'd45, 6'd46, 6'd47, 6'd0,  6'd0 },   // V
        '{6'd48, 6'd50, 6'd56, 6'd0,  6'd0,  6'd0 },   // stop
        '{6'd49, 6'd51, 6'd0,  6'd0,  6'd0,  6'd0 },   // Y
        '{6'd57, 6'd59, 6'd0,  6'd0,  6'd0,  6'd0 },   // C
        '{6'd58, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0 },   // W
        '{6'd61, 6'd63, 6'd0,  6'd0,  6'd0,  6'd0 }    // F
    };

    // Member k of family fam; out-of-range slots read as codon 0
    function automatic logic [5:0] fam_member(input logic [4:0] fam, input logic [2:0] k);
        logic [5:0] m;
        m = 6'd0;
        if ((int'(fam) < NUM_FAM) && (int'(k) < FAM_SLOTS))
        begin
            m = FAM_MEMBER[fam][k];
        end
        return m;
    endfunction

    function automatic logic [2:0] fam_size(input logic [4:0] fam);
        logic [2:0] s;
        s = 3'd1;
        if (int'(fam) < NUM_FAM)
        begin
            s = FAM_SIZE[fam];
        end
        return s;
    endfunction

    // Microprogram addresses
    typedef logic [2:0] upc_t;
    localparam upc_t UP_IDLE = 3'd0;
    localparam upc_t UP_RDT  = 3'd1;
    localparam upc_t UP_RDM  = 3'd2;
    localparam upc_t UP_ACC  = 3'd3;
    localparam upc_t UP_MUL  = 3'd4;
    localparam upc_t UP_DIV  = 3'd5;
    localparam upc_t UP_OUT  = 3'd6;
    localparam upc_t UP_ZOUT = 3'd7;

    // Branch conditions
    typedef enum logic [2:0] {
        CND_ALWAYS  = 3'd0,
        CND_QUERY   = 3'd1,
        CND_MORE    = 3'd2,
        CND_ZERO    = 3'd3,
        CND_LAST    = 3'd4,
        CND_OUTFREE = 3'd5
    } cond_t;

    typedef struct packed {
        logic  idle;      // input channel open
        logic  rd_tgt;    // read the queried codon's count
        logic  rd_mem;    // read next family member, if any left
        logic  lat_cnt;   // latch read data as the queried count
        logic  acc;       // add read data to the family sum
        logic  mul_init;  // numerator = size * count, start divider
        logic  div_step;  // one restoring division step
        logic  ld_out;    // load result register
        logic  ld_zero;   // load zero result with divide-by-zero status
        cond_t cond;
        upc_t  t_true;
        upc_t  t_false;
    } ucode_t;

    typedef struct packed {
        logic query;
        logic more;
        logic zero;
        logic last;
        logic out_free;
    } flags_t;

    // Control store
    function automatic ucode_t ucode_rom(input upc_t pc);
        ucode_t w;
        w = '0;
        w.cond = CND_ALWAYS;
        unique case (pc)
            UP_IDLE:
            begin
                w.idle = 1'b1; w.cond = CND_QUERY; w.t_true = UP_RDT; w.t_false = UP_IDLE;
            end
            UP_RDT:
            begin
                w.rd_tgt = 1'b1; w.t_true = UP_RDM;
            end
            UP_RDM:
            begin
                w.rd_mem = 1'b1; w.lat_cnt = 1'b1; w.t_true = UP_ACC;
            end
            UP_ACC:
            begin
                w.acc = 1'b1; w.rd_mem = 1'b1;
                w.cond = CND_MORE; w.t_true = UP_ACC; w.t_false = UP_MUL;
            end
            UP_MUL:
            begin
                w.mul_init = 1'b1; w.cond = CND_ZERO; w.t_true = UP_ZOUT; w.t_false = UP_DIV;
            end
            UP_DIV:
            begin
                w.div_step = 1'b1; w.cond = CND_LAST; w.t_true = UP_OUT; w.t_false = UP_DIV;
            end
            UP_OUT:
            begin
                w.ld_out = 1'b1; w.cond = CND_OUTFREE; w.t_true = UP_IDLE; w.t_false = UP_OUT;
            end
            UP_ZOUT:
            begin
                w.ld_zero = 1'b1; w.cond = CND_OUTFREE; w.t_true = UP_IDLE; w.t_false = UP_ZOUT;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== sv/cu_rscu_seq.sv =====
module cu_rscu_seq
(
    input  logic                clk,
    input  logic                rst_n,
    input  cu_rscu_pkg::flags_t flags,
    output cu_rscu_pkg::ucode_t cw
);

    cu_rscu_pkg::upc_t pc_reg;
    cu_rscu_pkg::upc_t pc_next;
    logic              take;

    // Current control word
    assign cw = cu_rscu_pkg::ucode_rom(pc_reg);

    // Branch condition select
    always_comb
    begin
        unique case (cw.cond)
            cu_rscu_pkg::CND_ALWAYS:  take = 1'b1;
            cu_rscu_pkg::CND_QUERY:   take = flags.query;
            cu_rscu_pkg::CND_MORE:    take = flags.more;
            cu_rscu_pkg::CND_ZERO:    take = flags.zero;
            cu_rscu_pkg::CND_LAST:    take = flags.last;
            cu_rscu_pkg::CND_OUTFREE: take = flags.out_free;
            default:                  take = 1'b1;
        endcase
        pc_next = take ? cw.t_true : cw.t_false;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= cu_rscu_pkg::UP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== sv/cu_rscu_datapath.sv =====
module cu_rscu_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cu_rscu_pkg::ucode_t                  cw,
    output cu_rscu_pkg::flags_t                  flags,
    input  logic                                 in_valid,
    input  logic                                 op,
    input  logic [5:0]                           codon,
    input  logic [cu_rscu_pkg::CNT_IN_W-1:0]     count_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [cu_rscu_pkg::RSCU_W-1:0]       rscu_fixed,
    output logic                                 status
);

    localparam int CB   = cu_rscu_pkg::COUNT_BITS;
    localparam int SW   = cu_rscu_pkg::SUM_W;
    localparam int RW   = cu_rscu_pkg::REM_W;
    localparam int QW   = cu_rscu_pkg::QUOT_W;
    localparam int OW   = cu_rscu_pkg::RSCU_W;
    localparam int STW  = cu_rscu_pkg::STEP_W;
    localparam int WXW  = CB + cu_rscu_pkg::CNT_IN_W;
    localparam int QXW  = QW + OW;

    // Count store with per-entry valid bits (cleared by reset)
    logic [CB-1:0] mem [64];
    logic [63:0]   vld_reg;
    logic [CB-1:0] rdata_reg;
    logic          rvld_reg;
    logic [CB-1:0] rdata;

    // Sequencer-driven working registers
    logic [5:0]    codon_reg;
    logic [4:0]    fam_reg;
    logic [2:0]    k_reg;
    logic [CB-1:0] cnt_reg;
    logic [SW-1:0] sum_reg;
    logic [RW-1:0] rem_reg;
    logic [QW-1:0] quot_reg;
    logic [STW-1:0] step_reg;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [OW-1:0] rscu_reg;
    logic          status_reg;

    logic          accept;
    logic          wr_en;
    logic [CB-1:0] wr_val;
    logic [WXW-1:0] wr_wide;
    logic [2:0]    size;
    logic          more;
    logic          rd_en;
    logic [5:0]    rd_addr;
    logic [RW-1:0] dvs;
    logic [RW-1:0] trial;
    logic          ge;
    logic [QXW-1:0] quot_wide;
    logic [OW-1:0] rscu_sat;
    logic          out_free;
    logic          ld_res;
    logic          ld_zero;

    assign accept  = in_valid && cw.idle;
    assign wr_en   = accept && !op;
    assign wr_wide = {{CB{1'b0}}, count_value};
    assign wr_val  = wr_wide[CB-1:0];

    assign size    = cu_rscu_pkg::fam_size(fam_reg);
    assign more    = (k_reg != size);
    assign rd_en   = cw.rd_tgt || (cw.rd_mem && more);
    assign rd_addr = cw.rd_tgt ? codon_reg : cu_rscu_pkg::fam_member(fam_reg, k_reg);
    assign rdata   = rvld_reg ? rdata_reg : '0;

    // Divisor is the family sum scaled by 8 so the numerator starts below it
    assign dvs   = RW'({sum_reg, 3'b000});
    assign trial = {rem_reg[RW-2:0], 1'b0};
    assign ge    = (trial >= dvs);

    // Saturate quotient to the output width
    assign quot_wide = {{OW{1'b0}}, quot_reg};
    assign rscu_sat  = (quot_wide[QXW-1:OW] != '0) ? {OW{1'b1}} : quot_wide[OW-1:0];

    assign out_free = !out_valid_reg || out_ready;
    assign ld_res   = cw.ld_out && out_free;
    assign ld_zero  = cw.ld_zero && out_free;

    assign flags.query    = accept && op;
    assign flags.more     = more;
    assign flags.zero     = (sum_reg == '0);
    assign flags.last     = (step_reg == STW'(1));
    assign flags.out_free = out_free;

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[codon] <= wr_val;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Valid bits and read-valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[codon] <= 1'b1;
            end
            if (rd_en)
            begin
                rvld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // Query capture, family sum, numerator, restoring divider and result register
    always_ff @(posedge clk)
    begin
        if (accept && op)
        begin
            codon_reg <= codon;
            fam_reg   <= cu_rscu_pkg::FAM_OF_CODON[codon];
            k_reg     <= 3'd0;
            sum_reg   <= '0;
        end
        else
        begin
            if (cw.rd_mem && more)
            begin
                k_reg <= k_reg + 3'd1;
            end
            if (cw.acc)
            begin
                sum_reg <= sum_reg + SW'(rdata);
            end
        end
        if (cw.lat_cnt)
        begin
            cnt_reg <= rdata;
        end
        if (cw.mul_init)
        begin
            rem_reg  <= RW'(SW'(cnt_reg) * SW'(size));
            quot_reg <= '0;
            step_reg <= STW'(QW);
        end
        else if (cw.div_step)
        begin
            rem_reg  <= ge ? (trial - dvs) : trial;
            quot_reg <= {quot_reg[QW-2:0], ge};
            step_reg <= step_reg - STW'(1);
        end
        if (ld_res)
        begin
            rscu_reg   <= rscu_sat;
            status_reg <= 1'b0;
        end
        else if (ld_zero)
        begin
            rscu_reg   <= '0;
            status_reg <= 1'b1;
        end
    end

    // Output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ld_res || ld_zero)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign rscu_fixed = rscu_reg;
    assign status     = status_reg;

    // Checks
    a_rem_below_dvs: assert property (@(posedge clk) disable iff (!rst_n)
        cw.div_step |-> (rem_reg < dvs))
        else $error("divider remainder not below divisor");

    a_sum_covers_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cw.mul_init |-> (sum_reg >= SW'(cnt_reg)))
        else $error("family sum below queried count");

    a_k_in_family: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.acc || cw.mul_init) |-> (k_reg <= size))
        else $error("member counter past family size");

    a_zero_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg) |-> (rscu_reg == '0))
        else $error("divide-by-zero result not zero");

    a_query_closes_in: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op) |=> !cw.idle)
        else $error("input still open after query transfer");

endmodule

// ===== sv/codon_usage_rscu.sv =====
// Relative synonymous codon usage over a 64-entry table of codon counts, all zero
// after reset. A write transfer (op 0) stores count_value for one codon. A query
// transfer (op 1) looks up the codon's synonymous family in the standard code
// (ATG alone is M, the stop codons form one family), sums the counts of its
// members through the single store read port, one member per cycle, then runs a
// restoring divider one quotient bit per cycle to form size*count/sum with
// FRAC_BITS fraction bits, truncated and saturated to the output width. The input
// stays closed from a query until its result is loaded; a zero family sum skips
// the divider and returns 0 with status 1. The result sits in an output register,
// so a write may follow while it waits.
module codon_usage_rscu
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             op,
    input  logic [5:0]                       codon,
    input  logic [cu_rscu_pkg::CNT_IN_W-1:0] count_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [cu_rscu_pkg::RSCU_W-1:0]   rscu_fixed,
    output logic                             status
);

    cu_rscu_pkg::ucode_t cw;
    cu_rscu_pkg::flags_t flags;

    assign in_ready = cw.idle;

    // Microcode sequencer
    cu_rscu_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .cw    (cw)
    );

    // Count store, accumulator, divider and result register
    cu_rscu_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cw          (cw),
        .flags       (flags),
        .in_valid    (in_valid),
        .op          (op),
        .codon       (codon),
        .count_value (count_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rscu_fixed  (rscu_fixed),
        .status      (status)
    );

endmodule

// ===== tb/sv/codon_usage_rscu_tb.sv =====
`timescale 1ns / 100ps

module codon_usage_rscu_tb;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic ST_OK       = 1'b0;
    localparam logic ST_ZERO_SUM = 1'b1;

    localparam int IDLE_PCT     = 17;
    localparam int RANDOM_ITEMS = 1725;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_REPORTS  = 10;

    localparam int CNT_W  = cu_rscu_pkg::CNT_IN_W;
    localparam int RES_W  = cu_rscu_pkg::RSCU_W;

    localparam logic [63:0] COUNT_MASK = (64'd1 << cu_rscu_pkg::COUNT_BITS) - 64'd1;
    localparam logic [63:0] RSCU_MAX   = (64'd1 << RES_W) - 64'd1;

    // Amino acid letter per codon, standard code, A=0 C=1 G=2 T=3
    localparam logic [0:64*8-1] AMINO_CODE = {
        "KNKNTTTTRSRSIIMI",
        "QHQHPPPPRRRRLLLL",
        "EDEDAAAAGGGGVVVV",
        "*Y*YSSSS*CWCLFLF"
    };

    typedef struct {
        logic             pause;      // hold off until all results are back
        logic             op;
        logic [5:0]       codon;
        logic [CNT_W-1:0] count;
    } codon_item_t;

    typedef struct {
        logic [RES_W-1:0] rscu;
        logic             status;
    } rscu_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic             op = OP_WRITE;
    logic [5:0]       codon = '0;
    logic [CNT_W-1:0] count_value = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [RES_W-1:0] rscu_fixed;
    logic             status;

    codon_item_t  pending_items [$];
    rscu_result_t rscu_expected [$];
    logic [63:0]  codon_counts [64];

    int n_accepted = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    logic calm_stretch;

    codon_usage_rscu dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .codon       (codon),
        .count_value (count_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rscu_fixed  (rscu_fixed),
        .status      (status)
    );

    always #5 clk = ~clk;

    // No idling on either side over a stretch of the random part
    assign calm_stretch = (n_accepted >= 900) && (n_accepted < 1200);

    function automatic logic [7:0] amino_of(input logic [5:0] c);
        return AMINO_CODE[8*c +: 8];
    endfunction

    // RSCU of one codon over the current count table
    function automatic rscu_result_t rscu_of(input logic [5:0] c);
        rscu_result_t r;
        logic [63:0]  fam_sum;
        logic [63:0]  fam_size;
        logic [63:0]  quo;
        fam_sum  = '0;
        fam_size = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (amino_of(6'(i)) == amino_of(c))
            begin
                fam_size += 64'd1;
                fam_sum  += codon_counts[i];
            end
        end
        if (fam_sum == 64'd0)
        begin
            r.rscu   = '0;
            r.status = ST_ZERO_SUM;
        end
        else
        begin
            // truncating divide, same as a restoring divider
            quo = ((fam_size * codon_counts[c]) << cu_rscu_pkg::FRAC_BITS) / fam_sum;
            if (quo > RSCU_MAX)
            begin
                quo = RSCU_MAX;
            end
            r.rscu   = quo[RES_W-1:0];
            r.status = ST_OK;
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] random_count();
        logic [CNT_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = '0;
            3:       v = '1;
            4, 5:    v = CNT_W'($urandom_range(1, 15));
            default: v = CNT_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic push_write(input logic [5:0] c, input logic [CNT_W-1:0] v);
        codon_item_t it;
        it.pause = 1'b0;
        it.op    = OP_WRITE;
        it.codon = c;
        it.count = v;
        pending_items.push_back(it);
    endtask

    task automatic push_query(input logic [5:0] c);
        codon_item_t it;
        it.pause = 1'b0;
        it.op    = OP_QUERY;
        it.codon = c;
        it.count = CNT_W'($urandom);
        pending_items.push_back(it);
    endtask

    task automatic push_pause();
        codon_item_t it;
        it.pause = 1'b1;
        it.op    = OP_WRITE;
        it.codon = '0;
        it.count = '0;
        pending_items.push_back(it);
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // Driver: present queued items, update the count table on each write transfer
    always @(posedge clk)
    begin : drive_proc
        codon_item_t nxt;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            op          <= OP_WRITE;
            codon       <= '0;
            count_value <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                n_accepted <= n_accepted + 1;
                if (op == OP_WRITE)
                begin
                    codon_counts[codon] = 64'(count_value) & COUNT_MASK;
                end
                else
                begin
                    rscu_expected.push_back(rscu_of(codon));
                end
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && pending_items[0].pause)
                begin
                    if (rscu_expected.size() == 0)
                    begin
                        void'(pending_items.pop_front());
                    end
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0 &&
                         (calm_stretch || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    nxt = pending_items.pop_front();
                    in_valid    <= 1'b1;
                    op          <= nxt.op;
                    codon       <= nxt.codon;
                    count_value <= nxt.count;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, compare each result transfer
    always @(posedge clk)
    begin : check_proc
        rscu_result_t want;
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            out_ready <= calm_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (out_valid && out_ready)
            begin
                if (rscu_expected.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected result rscu=%0d status=%0d",
                                            rscu_fixed, status));
                end
                else
                begin
                    want = rscu_expected.pop_front();
                    if (rscu_fixed !== want.rscu || status !== want.status)
                    begin
                        note_mismatch($sformatf("expected rscu=%0d status=%0d, got rscu=%0d status=%0d",
                                                want.rscu, want.status, rscu_fixed, status));
                    end
                end
            end
        end
    end

    initial
    begin : stim_proc
        logic timed_out;
        timed_out = 1'b0;
        for (int i = 0; i < 64; i++)
        begin
            codon_counts[i] = '0;
        end

        // Directed: empty families, single-codon families, full counts, truncation
        push_query(6'd14);                 // M, all zero after reset
        push_query(6'd63);
        push_write(6'd14, '1);
        push_query(6'd14);
        push_write(6'd28, '1);             // L family, one member full
        push_query(6'd28);                 // 6.0
        push_query(6'd60);                 // zero count, nonzero family
        push_write(6'd62, '1);
        push_query(6'd28);
        push_write(6'd58, 32'd1);          // W
        push_query(6'd58);
        push_write(6'd48, 32'd1);          // stop codons
        push_write(6'd50, 32'd2);
        push_query(6'd56);
        push_query(6'd50);
        push_write(6'd0, 32'd3);           // K
        push_query(6'd0);
        push_write(6'd2, 32'd1);
        push_query(6'd0);
        push_query(6'd2);
        push_write(6'd4, 32'd1);           // T, fraction truncated
        push_write(6'd5, 32'd2);
        push_query(6'd4);
        push_write(6'd14, '0);             // back to an empty family
        push_query(6'd14);
        push_pause();

        // Random mix of writes and queries
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                push_pause();
            end
            if ($urandom_range(0, 1) == 0)
            begin
                push_write(6'($urandom_range(0, 63)), random_count());
            end
            else
            begin
                push_query(6'($urandom_range(0, 63)));
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (!(pending_items.size() == 0 && !in_valid && rscu_expected.size() == 0) &&
               !timed_out)
        begin
            @(posedge clk);
            timed_out = (quiet_cycles >= QUIET_LIMIT);
        end
        if (!timed_out)
        begin
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
        if (!timed_out && mismatches == 0 && rscu_expected.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/cu_rscu_pkg.sv
sv/cu_rscu_seq.sv
sv/cu_rscu_datapath.sv
sv/codon_usage_rscu.sv
tb/sv/codon_usage_rscu_tb.sv
